// ===== design/sparse_set_with_random_pick_macros.svh =====
// Assertion macros shared by the sparse set design files.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPARSE_SET_WITH_RANDOM_PICK_MACROS_SVH
`define SPARSE_SET_WITH_RANDOM_PICK_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SSRP_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must follow its antecedent, checked with a non-overlapping implication.
`define SSRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ssrp_pkg.sv =====
// Package for the sparse set with random pick: sizes, codes, command and status types.
// Depends on nothing; used by every module of the block.
package ssrp_pkg;

   localparam int CAP      = 256;
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 8;
   localparam int SLOT_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;
   localparam int RNG_W    = 32;

   localparam logic [RNG_W-1:0] RNG_SEED = 32'd1234567;

   localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PICK     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXTRACT  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAP);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                ins_write;
      logic                clear_all;
      logic                set_found;
      logic                set_status;
      logic [STATUS_W-1:0] status_val;
      logic                drop_read;
      logic                mod_start;
      logic                pick_read;
      logic                pick_take;
      logic                drop_write;
      logic                rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic              empty;
      logic              full;
      logic              mod_done;
      logic              rsp_busy;
   } stat_type;

   // One xorshift32 step.
   function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
      logic [RNG_W-1:0] a;
      logic [RNG_W-1:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

// ===== design/ssrp_ifs.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on ssrp_pkg for field widths.
interface ssrp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ssrp_pkg::KIND_W-1:0]   kind;
   logic [ssrp_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ssrp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [ssrp_pkg::VALUE_W-1:0]   picked;
   logic [ssrp_pkg::COUNT_W-1:0]   count;
   logic [ssrp_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output found, output picked, output count,
                   output status, input ready);
   modport sink   (input valid, input found, input picked, input count,
                   input status, output ready);
endinterface

// ===== design/ssrp_mod.sv =====
// Iterative remainder unit: 32-bit dividend modulo the member count, one bit per cycle.
// Depends on ssrp_pkg for widths.
module ssrp_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ssrp_pkg::RNG_W-1:0]      dividend,
   input  logic [ssrp_pkg::COUNT_W-1:0]    divisor,
   output logic                            done,
   output logic [ssrp_pkg::SLOT_W-1:0]     rem
);

   localparam int CNT_W = $clog2(ssrp_pkg::RNG_W);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [ssrp_pkg::RNG_W-1:0]     shift_ff, shift_in;
   logic [ssrp_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [ssrp_pkg::COUNT_W-1:0]   div_ff, div_in;
   logic [ssrp_pkg::COUNT_W:0]     trial;

   // Restoring step: bring in the next dividend bit, subtract when it fits.
   assign trial = {rem_ff, shift_ff[ssrp_pkg::RNG_W-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(ssrp_pkg::RNG_W - 1);
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = ssrp_pkg::COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[ssrp_pkg::COUNT_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[ssrp_pkg::SLOT_W-1:0];

endmodule

// ===== design/ssrp_ctrl.sv =====
// Controller state machine for the sparse set: sequences each request word.
// Depends on ssrp_pkg for codes and the command and status structs.
module ssrp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ssrp_pkg::stat_type stat,
   output ssrp_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECODE   = 3'd1;
   localparam logic [2:0] ST_MOD_WAIT = 3'd2;
   localparam logic [2:0] ST_PICK_RD  = 3'd3;
   localparam logic [2:0] ST_DROP_WR  = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            unique case (stat.kind)
               ssrp_pkg::KIND_INSERT: begin
                  cmd.ins_write = !stat.hit && !stat.full;
               end
               ssrp_pkg::KIND_REMOVE: begin
                  if (stat.hit && !stat.empty) begin
                     cmd.drop_read = 1'b1;
                     state_in      = ST_DROP_WR;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ssrp_pkg::STATUS_ABSENT;
                  end
               end
               ssrp_pkg::KIND_CONTAINS: begin
                  cmd.set_found = 1'b1;
               end
               ssrp_pkg::KIND_PICK, ssrp_pkg::KIND_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ssrp_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.mod_start = 1'b1;
                     state_in      = ST_MOD_WAIT;
                  end
               end
               ssrp_pkg::KIND_CLEAR: begin
                  cmd.clear_all = 1'b1;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_MOD_WAIT: begin
            if (stat.mod_done) begin
               cmd.pick_read = 1'b1;
               state_in      = ST_PICK_RD;
            end
         end
         ST_PICK_RD: begin
            cmd.pick_take = 1'b1;
            if (stat.kind == ssrp_pkg::KIND_EXTRACT) begin
               cmd.drop_read = 1'b1;
               state_in      = ST_DROP_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DROP_WR: begin
            cmd.drop_write = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/ssrp_dpath.sv =====
// Datapath for the sparse set: element and position memories, presence bits,
// count, random generator, remainder unit and the response register.
// Depends on ssrp_pkg, ssrp_mod and the assertion macros header.
`include "sparse_set_with_random_pick_macros.svh"

module ssrp_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ssrp_pkg::cmd_type               cmd,
   output ssrp_pkg::stat_type              stat,
   input  logic [ssrp_pkg::KIND_W-1:0]     req_kind,
   input  logic [ssrp_pkg::VALUE_W-1:0]    req_value,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_found,
   output logic [ssrp_pkg::VALUE_W-1:0]    rsp_picked,
   output logic [ssrp_pkg::COUNT_W-1:0]    rsp_count,
   output logic [ssrp_pkg::STATUS_W-1:0]   rsp_status
);

   // Memories: dense member list and value-to-slot map.
   logic [ssrp_pkg::VALUE_W-1:0] elements [ssrp_pkg::CAP];
   logic [ssrp_pkg::SLOT_W-1:0]  positions [ssrp_pkg::CAP];

   logic [ssrp_pkg::CAP-1:0]       present_ff, present_in;
   logic [ssrp_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ssrp_pkg::RNG_W-1:0]     rng_ff, rng_in;
   logic [ssrp_pkg::KIND_W-1:0]    kind_ff;
   logic [ssrp_pkg::VALUE_W-1:0]   target_ff;
   logic                           found_ff;
   logic [ssrp_pkg::VALUE_W-1:0]   picked_ff;
   logic [ssrp_pkg::STATUS_W-1:0]  status_ff;
   logic [ssrp_pkg::VALUE_W-1:0]   elem_rd_ff;
   logic [ssrp_pkg::SLOT_W-1:0]    pos_rd_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_found_ff;
   logic [ssrp_pkg::VALUE_W-1:0]   rsp_picked_ff;
   logic [ssrp_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic [ssrp_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic [ssrp_pkg::SLOT_W-1:0]    last_slot;
   logic [ssrp_pkg::SLOT_W-1:0]    elem_rd_addr;
   logic [ssrp_pkg::VALUE_W-1:0]   pos_rd_addr;
   logic                           mod_done;
   logic [ssrp_pkg::SLOT_W-1:0]    mod_rem;

   assign last_slot = ssrp_pkg::SLOT_W'(count_ff - 1'b1);

   ssrp_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (rng_in),
      .divisor  (count_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      stat.kind     = kind_ff;
      stat.hit      = present_ff[target_ff];
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == ssrp_pkg::COUNT_FULL);
      stat.mod_done = mod_done;
      stat.rsp_busy = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      rng_in     = rng_ff;
      if (cmd.clear_all) begin
         present_in = '0;
         count_in   = '0;
      end
      if (cmd.ins_write) begin
         present_in[target_ff] = 1'b1;
         count_in              = count_ff + 1'b1;
      end
      if (cmd.drop_write) begin
         present_in[target_ff] = 1'b0;
         count_in              = count_ff - 1'b1;
      end
      if (cmd.mod_start) begin
         rng_in = ssrp_pkg::xorshift(rng_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         count_ff   <= '0;
         rng_ff     <= ssrp_pkg::RNG_SEED;
      end else begin
         present_ff <= present_in;
         count_ff   <= count_in;
         rng_ff     <= rng_in;
      end
   end

   // Element memory: one read port, one write port.
   assign elem_rd_addr = cmd.drop_read ? last_slot : mod_rem;

   always_ff @(posedge clock) begin
      if (cmd.drop_read || cmd.pick_read) begin
         elem_rd_ff <= elements[elem_rd_addr];
      end
      if (cmd.ins_write) begin
         elements[count_ff[ssrp_pkg::SLOT_W-1:0]] <= target_ff;
      end else if (cmd.drop_write) begin
         elements[pos_rd_ff] <= elem_rd_ff;
      end
   end

   // Position memory: the picked member is looked up straight from the read register.
   assign pos_rd_addr = cmd.pick_take ? elem_rd_ff : target_ff;

   always_ff @(posedge clock) begin
      if (cmd.drop_read) begin
         pos_rd_ff <= positions[pos_rd_addr];
      end
      if (cmd.ins_write) begin
         positions[target_ff] <= count_ff[ssrp_pkg::SLOT_W-1:0];
      end else if (cmd.drop_write) begin
         positions[elem_rd_ff] <= pos_rd_ff;
      end
   end

   // Working registers for the current request word.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         target_ff <= req_value;
         found_ff  <= 1'b0;
         picked_ff <= '0;
         status_ff <= ssrp_pkg::STATUS_OK;
      end else begin
         if (cmd.ins_write) begin
            found_ff <= 1'b1;
         end
         if (cmd.set_found) begin
            found_ff <= present_ff[target_ff];
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_val;
         end
         if (cmd.pick_take) begin
            picked_ff <= elem_rd_ff;
            target_ff <= elem_rd_ff;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_picked_ff <= picked_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_picked = rsp_picked_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   `SSRP_ASSERT_HOLDS(a_count_in_range, clock, reset, count_ff <= ssrp_pkg::COUNT_FULL, "member count above capacity")
   `SSRP_ASSERT_HOLDS(a_mod_below_count, clock, reset, !mod_done || ({1'b0, mod_rem} < count_ff), "pick slot not below member count")
   `SSRP_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.ins_write, count_ff == $past(count_ff) + 9'd1, "insert did not grow the count by one")
   `SSRP_ASSERT_NEXT(a_drop_shrinks, clock, reset, cmd.drop_write, count_ff == $past(count_ff) - 9'd1, "drop did not shrink the count by one")

endmodule

// ===== design/sparse_set_with_random_pick.sv =====
// Channel   Dir  Fields                          Notes
// req_chan  in   kind[3], value[8]               one operation word
// rsp_chan  out  found, picked[8], count[9],     one result word per operation
//                status[2]
//
// Insert, remove, contains and clear run through decode (remove also through a drop write)
// to the final state and the result register; random pick and random extract also wait on
// the 32-step bit-serial remainder unit that reduces the generator output.
// One operation is in flight at a time; a new word is accepted while the previous
// result still waits in the output register, and the block stalls in its final
// state until that register is free. Reset is synchronous and active high; clear
// empties the set at once because presence is kept in flip-flops.
//
// Depends on ssrp_pkg, ssrp_ifs, ssrp_ctrl and ssrp_dpath.
module sparse_set_with_random_pick (
   input logic        clock,
   input logic        reset,
   ssrp_req_if.sink   req_chan,
   ssrp_rsp_if.source rsp_chan
);

   ssrp_pkg::cmd_type  cmd;
   ssrp_pkg::stat_type stat;
   logic               ready;

   // The controller sequences each word; all storage lives in the datapath.
   ssrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = ready;

   ssrp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_chan.kind),
      .req_value  (req_chan.value),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_found  (rsp_chan.found),
      .rsp_picked (rsp_chan.picked),
      .rsp_count  (rsp_chan.count),
      .rsp_status (rsp_chan.status)
   );

endmodule

// ===== dv/ssrp_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sparse set testbench: a mirror of the set and the queue of result words.
// Depends on ssrp_pkg for widths, operation kinds and status codes.
package ssrp_tb_pkg;

   typedef struct packed {
      logic                          found;
      logic [ssrp_pkg::VALUE_W-1:0]  picked;
      logic [ssrp_pkg::COUNT_W-1:0]  count;
      logic [ssrp_pkg::STATUS_W-1:0] status;
   } rsp_word_type;

   class set_scoreboard;
      bit [ssrp_pkg::VALUE_W-1:0] members [ssrp_pkg::CAP];
      bit [ssrp_pkg::COUNT_W-1:0] slot_of [ssrp_pkg::CAP];
      bit                         present [ssrp_pkg::CAP];
      bit [ssrp_pkg::COUNT_W-1:0] member_total;
      bit [ssrp_pkg::RNG_W-1:0]   rng;
      rsp_word_type               expected_q [$];
      int                         errors;

      function new();
         for (int i = 0; i < ssrp_pkg::CAP; i++) begin
            members[i] = '0;
            slot_of[i] = '0;
            present[i] = 1'b0;
         end
         member_total = '0;
         rng = ssrp_pkg::RNG_SEED;
         errors = 0;
      endfunction

      // Move the last member into the slot of v and shrink the set.
      function void drop_member(int v);
         int slot;
         int last;
         slot = int'(slot_of[v]);
         last = int'(members[member_total - 1]);
         members[slot] = ssrp_pkg::VALUE_W'(last);
         slot_of[last] = ssrp_pkg::COUNT_W'(slot);
         member_total = member_total - 1'b1;
         present[v] = 1'b0;
      endfunction

      // Apply one accepted request word to the mirror and queue its result.
      function void note_request(logic [ssrp_pkg::KIND_W-1:0] kind,
                                 logic [ssrp_pkg::VALUE_W-1:0] value);
         rsp_word_type word;
         int           v;
         int           slot;
         word = '0;
         v = int'(value);
         case (kind)
            ssrp_pkg::KIND_INSERT: begin
               if (!present[v] && member_total < ssrp_pkg::COUNT_FULL) begin
                  slot_of[v] = member_total;
                  present[v] = 1'b1;
                  members[member_total] = value;
                  member_total = member_total + 1'b1;
                  word.found = 1'b1;
               end
            end
            ssrp_pkg::KIND_REMOVE: begin
               if (present[v] && member_total != 0) begin
                  drop_member(v);
               end else begin
                  word.status = ssrp_pkg::STATUS_ABSENT;
               end
            end
            ssrp_pkg::KIND_CONTAINS: begin
               word.found = present[v];
            end
            ssrp_pkg::KIND_PICK, ssrp_pkg::KIND_EXTRACT: begin
               if (member_total == 0) begin
                  word.status = ssrp_pkg::STATUS_EMPTY;
               end else begin
                  rng = rng ^ (rng << 13);
                  rng = rng ^ (rng >> 17);
                  rng = rng ^ (rng << 5);
                  slot = int'(rng % ssrp_pkg::RNG_W'(member_total));
                  word.picked = members[slot];
                  if (kind == ssrp_pkg::KIND_EXTRACT) begin
                     drop_member(int'(word.picked));
                  end
               end
            end
            ssrp_pkg::KIND_CLEAR: begin
               for (int i = 0; i < ssrp_pkg::CAP; i++) begin
                  present[i] = 1'b0;
               end
               member_total = '0;
            end
            default: begin
            end
         endcase
         word.count = member_total;
         expected_q.insert(expected_q.size(), word);
      endfunction

      task report_mismatch(string what);
         $display("tb: mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      // Compare one accepted result word with the oldest expectation.
      task check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result word %h arrived with nothing expected", got));
         end else begin
            want = expected_q.pop_front();
            if (got.found !== want.found)
               report_mismatch($sformatf("found %h, expected %h", got.found, want.found));
            if (got.picked !== want.picked)
               report_mismatch($sformatf("picked %h, expected %h", got.picked, want.picked));
            if (got.count !== want.count)
               report_mismatch($sformatf("count %h, expected %h", got.count, want.count));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %h, expected %h", got.status, want.status));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top level of the sparse set testbench: clock, reset, request driver and response sink.
// Depends on ssrp_pkg, ssrp_ifs, ssrp_tb_pkg and the sparse_set_with_random_pick design.
module tb;

   // The two kinds that the block treats as no operation.
   localparam logic [ssrp_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [ssrp_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   // The limit leaves ample margin over the slowest correct run.
   localparam int CYCLE_LIMIT = 400000;
   // Idle clocks waited after the final drain, before the verdict.
   localparam int TAIL_CYCLES = 120;

   logic clock;
   logic reset;

   ssrp_req_if req_chan ();
   ssrp_rsp_if rsp_chan ();

   sparse_set_with_random_pick u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ssrp_tb_pkg::set_scoreboard sb;

   // When calm is set, neither side idles. This covers the last part of the run.
   bit calm;
   int cycle_count;
   int ready_left;
   bit ready_stall;

   always #1 clock = ~clock;

   // Every accepted request word updates the mirror and queues one expected result word.
   // Every accepted result word is checked against the oldest expectation. Both sample
   // at the rising edge, where the inputs driven at the falling edge are stable.
   always @(posedge clock) begin
      if (!reset && req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
         sb.note_request(req_chan.kind, req_chan.value);
      end
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         sb.check_result('{rsp_chan.found, rsp_chan.picked, rsp_chan.count, rsp_chan.status});
      end
   end

   // The response side alternates stretches of readiness with stall bursts. Both lengths
   // are drawn at random, so stalls land on every phase of the work.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            ready_stall = 1'b1;
            ready_left = $urandom_range(1, 15);
         end else begin
            ready_stall = 1'b0;
            ready_left = $urandom_range(1, 20);
         end
      end
      ready_left--;
      rsp_chan.ready <= !ready_stall;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Present one request word and hold it until the block takes it. Now and then an idle gap
   // comes first. Valid is assigned once per falling edge, so a word that directly follows an
   // accepted one keeps valid high without a glitch.
   task automatic send_word(input logic [ssrp_pkg::KIND_W-1:0] k,
                            input logic [ssrp_pkg::VALUE_W-1:0] v);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.kind  <= k;
      req_chan.value <= v;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Drop valid and hold off until every expected result word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One operation of a well-formed random mix. Operands mostly come from a narrow
   // window, so removes and contains often hit members; some are drawn from the full range.
   task automatic send_mixed(input int lo, input int hi);
      int r;
      logic [ssrp_pkg::KIND_W-1:0] k;
      logic [ssrp_pkg::VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 32)
         k = ssrp_pkg::KIND_INSERT;
      else if (r < 52)
         k = ssrp_pkg::KIND_REMOVE;
      else if (r < 66)
         k = ssrp_pkg::KIND_CONTAINS;
      else if (r < 80)
         k = ssrp_pkg::KIND_PICK;
      else if (r < 94)
         k = ssrp_pkg::KIND_EXTRACT;
      else if (r < 96)
         k = ssrp_pkg::KIND_CLEAR;
      else
         k = ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      if ($urandom_range(0, 7) == 0)
         v = ssrp_pkg::VALUE_W'($urandom_range(0, 255));
      else
         v = ssrp_pkg::VALUE_W'($urandom_range(lo, hi));
      send_word(k, v);
   endtask

   initial begin
      int perm [ssrp_pkg::CAP];
      int j;
      int tmp;
      int lo;
      int width;

      sb = new();
      calm = 1'b0;
      cycle_count = 0;
      ready_left = 0;
      ready_stall = 1'b0;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind  = ssrp_pkg::KIND_INSERT;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. An empty set must reject pick and extract without touching the
      // generator, and a remove of an absent value must leave the set unchanged.
      send_word(ssrp_pkg::KIND_PICK, 8'h00);
      send_word(ssrp_pkg::KIND_EXTRACT, 8'hff);
      send_word(ssrp_pkg::KIND_REMOVE, 8'h00);
      send_word(ssrp_pkg::KIND_CONTAINS, 8'hff);
      // Extreme values, and a duplicate insert that must be ignored.
      send_word(ssrp_pkg::KIND_INSERT, 8'h00);
      send_word(ssrp_pkg::KIND_INSERT, 8'h00);
      send_word(ssrp_pkg::KIND_INSERT, 8'hff);
      send_word(ssrp_pkg::KIND_CONTAINS, 8'h00);
      send_word(ssrp_pkg::KIND_CONTAINS, 8'hff);
      send_word(ssrp_pkg::KIND_CONTAINS, 8'h80);
      send_word(ssrp_pkg::KIND_PICK, 8'h00);
      send_word(ssrp_pkg::KIND_PICK, 8'h00);
      send_word(ssrp_pkg::KIND_EXTRACT, 8'h00);
      send_word(ssrp_pkg::KIND_REMOVE, 8'hff);
      send_word(ssrp_pkg::KIND_REMOVE, 8'h00);
      // The unused kinds are no operations.
      send_word(KIND_SPARE_LO, 8'haa);
      send_word(KIND_SPARE_HI, 8'h55);
      // Clear with members present, then check that they are all gone.
      send_word(ssrp_pkg::KIND_INSERT, 8'h01);
      send_word(ssrp_pkg::KIND_INSERT, 8'h02);
      send_word(ssrp_pkg::KIND_INSERT, 8'h03);
      send_word(ssrp_pkg::KIND_PICK, 8'h00);
      send_word(ssrp_pkg::KIND_CLEAR, 8'h00);
      send_word(ssrp_pkg::KIND_CONTAINS, 8'h01);
      send_word(ssrp_pkg::KIND_PICK, 8'h00);
      send_word(ssrp_pkg::KIND_REMOVE, 8'h02);
      send_word(ssrp_pkg::KIND_INSERT, 8'h02);

      // Random mix over a sliding operand window.
      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) lo = $urandom_range(0, 224);
         send_mixed(lo, lo + 31);
      end

      // Let the pipeline run dry before the fill phase.
      wait_drained();

      // Fill the set with every value in shuffled order, probe it while full, then drain
      // part of it by random extraction.
      for (int i = 0; i < ssrp_pkg::CAP; i++) perm[i] = i;
      for (int i = ssrp_pkg::CAP - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      send_word(ssrp_pkg::KIND_CLEAR, 8'h00);
      for (int i = 0; i < ssrp_pkg::CAP; i++)
         send_word(ssrp_pkg::KIND_INSERT, ssrp_pkg::VALUE_W'(perm[i]));
      // A full set ignores every further insert.
      for (int i = 0; i < 8; i++)
         send_word(ssrp_pkg::KIND_INSERT, ssrp_pkg::VALUE_W'($urandom_range(0, 255)));
      for (int i = 0; i < 10; i++)
         send_word(ssrp_pkg::KIND_CONTAINS, ssrp_pkg::VALUE_W'($urandom_range(0, 255)));
      for (int i = 0; i < 20; i++) send_word(ssrp_pkg::KIND_PICK, 8'h00);
      for (int i = 0; i < 100; i++)
         send_word(ssrp_pkg::KIND_EXTRACT, ssrp_pkg::VALUE_W'($urandom_range(0, 255)));
      for (int i = 0; i < 10; i++)
         send_word(ssrp_pkg::KIND_REMOVE, ssrp_pkg::VALUE_W'($urandom_range(0, 255)));

      // Random mix with wider windows. The last stretch runs without idling.
      for (int i = 0; i < 400; i++) begin
         if (i == 250) calm = 1'b1;
         if (i % 40 == 0) begin
            width = $urandom_range(0, 1) ? 63 : 255;
            lo = $urandom_range(0, 255 - width);
         end
         send_mixed(lo, lo + width);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
